FILE: sv/kedl_pkg.sv
package kedl_pkg;

    // Widths fixed by the item format.
    localparam int PATH_KEY_W = 32;
    localparam int TS_W       = 32;
    localparam int CFG_W      = 24;
    localparam int IN_TDATA_W = 64;
    localparam int OUT_TDATA_W = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_KEY_BITS    = 32;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UNLINK = 5'b01000,
        ST_LINK   = 5'b10000
    } t_state;

    // Number of bits needed to address a table of the given depth.
    function automatic int idx_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

FILE: sv/kedl_ram.sv
module kedl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [kedl_pkg::idx_bits(DEPTH)-1:0]      i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [kedl_pkg::idx_bits(DEPTH)-1:0]      i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/keyed_event_debounce_lru_core.sv
// After a request is accepted the key/time memory is read one slot per cycle up to the first
// key match (every used slot on a miss); the decide state then registers the result once the
// result register is free or being taken. One request is handled at a time: after the
// decision the list may be updated in the unlink and link states, and the next request is
// taken only back in idle.
// Reset (synchronous, active low) empties the table via its fill count, zeroes the window.
module keyed_event_debounce_lru_core #(
    parameter int TABLE_DEPTH = kedl_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = kedl_pkg::DEF_KEY_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Configuration write channel: debounce_interval.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kedl_pkg::CFG_W-1:0]          i_cfg_data,

    // Event request stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0 up: path_key[31:0], now[63:32].
    input  logic [kedl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0 up: dispatch[0], zero padding[7:1].
    output logic [kedl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int IW = kedl_pkg::idx_bits(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = kedl_pkg::TS_W;
    localparam int DW = KEY_BITS + TW;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    // The table lives in three memories. The entry memory holds {time, key} per slot.
    // Recency order is a doubly linked list (prev/next memories) from r_head (most recent)
    // to r_tail (oldest). Slots fill in order, so slot i is valid exactly when i < r_used.

    kedl_pkg::t_state r_state, n_state;

    logic [kedl_pkg::CFG_W-1:0] r_interval, n_interval;
    logic [CW-1:0]  r_used, n_used;
    logic [IW-1:0]  r_head, n_head;
    logic [IW-1:0]  r_tail, n_tail;

    // Current request.
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [TW-1:0]       r_now, n_now;

    // Search pipeline.
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_rvalid, n_rvalid;
    logic [IW-1:0]  r_ridx, n_ridx;

    // Search results: the matching slot and the oldest slot.
    logic           r_hit, n_hit;
    logic [TW-1:0]  r_htime, n_htime;
    logic [TW-1:0]  r_ttime, n_ttime;
    logic [IW-1:0]  r_tprev, n_tprev;

    // Slot that moves to the front, with its neighbors.
    logic [IW-1:0]  r_v, n_v;
    logic [IW-1:0]  r_vp, n_vp;
    logic [IW-1:0]  r_vn, n_vn;
    logic           r_vtail, n_vtail;

    // Result register.
    logic           r_out_valid, n_out_valid;
    logic           r_dispatch, n_dispatch;

    // Memory ports.
    logic [DW-1:0]  data_rd;
    logic [IW-1:0]  prev_rd, next_rd;
    logic           rd_en;
    logic           data_we;
    logic [IW-1:0]  data_waddr;
    logic           link_we;
    logic [IW-1:0]  next_waddr, next_wdata;
    logic [IW-1:0]  prev_waddr, prev_wdata;

    logic [KEY_BITS+kedl_pkg::PATH_KEY_W-1:0] key_ext;
    logic [KEY_BITS-1:0] in_key;
    logic [KEY_BITS-1:0] rd_key;
    logic [TW-1:0]       rd_time;
    logic                scan_match;
    logic                in_accept;
    logic                decide_go;
    logic [TW-1:0]       age;
    logic                in_window;

    // Only the low KEY_BITS bits of the key take part; narrower inputs are zero-extended.
    assign key_ext = {{KEY_BITS{1'b0}}, s_axis_tdata[kedl_pkg::PATH_KEY_W-1:0]};
    assign in_key  = key_ext[KEY_BITS-1:0];

    assign rd_key  = data_rd[KEY_BITS-1:0];
    assign rd_time = data_rd[DW-1:KEY_BITS];

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign scan_match = r_rvalid && (rd_key == r_key);
    assign rd_en      = (r_state == kedl_pkg::ST_SCAN) && (r_cnt < r_used) && !scan_match;
    assign decide_go  = (r_state == kedl_pkg::ST_DECIDE) && (!r_out_valid || m_axis_tready);

    // Age of the entry under decision: the matching entry on a hit, the oldest on a miss.
    assign age       = r_now - (r_hit ? r_htime : r_ttime);
    assign in_window = age < TW'(r_interval);

    always_comb begin
        n_state     = r_state;
        n_interval  = r_interval;
        n_used      = r_used;
        n_head      = r_head;
        n_tail      = r_tail;
        n_key       = r_key;
        n_now       = r_now;
        n_cnt       = r_cnt;
        n_rvalid    = 1'b0;
        n_ridx      = r_ridx;
        n_hit       = r_hit;
        n_htime     = r_htime;
        n_ttime     = r_ttime;
        n_tprev     = r_tprev;
        n_v         = r_v;
        n_vp        = r_vp;
        n_vn        = r_vn;
        n_vtail     = r_vtail;
        n_dispatch  = r_dispatch;
        n_out_valid = r_out_valid && !m_axis_tready;

        data_we    = 1'b0;
        data_waddr = r_v;
        link_we    = 1'b0;
        next_waddr = r_v;
        next_wdata = r_head;
        prev_waddr = r_head;
        prev_wdata = r_v;

        if (i_cfg_valid) begin
            n_interval = i_cfg_data;
        end

        unique case (r_state)
            kedl_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_key   = in_key;
                    n_now   = s_axis_tdata[kedl_pkg::IN_TDATA_W-1:kedl_pkg::PATH_KEY_W];
                    n_cnt   = '0;
                    n_hit   = 1'b0;
                    n_state = (r_used == '0) ? kedl_pkg::ST_DECIDE : kedl_pkg::ST_SCAN;
                end
            end

            kedl_pkg::ST_SCAN: begin
                if (rd_en) begin
                    n_cnt    = r_cnt + CW'(1);
                    n_ridx   = r_cnt[IW-1:0];
                    n_rvalid = 1'b1;
                end
                if (r_rvalid && (r_ridx == r_tail)) begin
                    n_ttime = rd_time;
                    n_tprev = prev_rd;
                end
                if (scan_match) begin
                    n_hit   = 1'b1;
                    n_htime = rd_time;
                    n_v     = r_ridx;
                    n_vp    = prev_rd;
                    n_vn    = next_rd;
                end
                // Reads go out back to back, so data returning while the count has reached
                // the fill level is the last entry.
                if (r_rvalid && (scan_match || (r_cnt == r_used))) begin
                    n_state = kedl_pkg::ST_DECIDE;
                end
            end

            kedl_pkg::ST_DECIDE: begin
                if (decide_go) begin
                    n_out_valid = 1'b1;
                    n_dispatch  = 1'b1;
                    n_state     = kedl_pkg::ST_IDLE;
                    if (r_hit) begin
                        if (in_window) begin
                            // Suppressed: the table stays as it is.
                            n_dispatch = 1'b0;
                        end else begin
                            data_we    = 1'b1;
                            data_waddr = r_v;
                            n_vtail    = (r_v == r_tail);
                            if (r_v != r_head) begin
                                n_state = kedl_pkg::ST_UNLINK;
                            end
                        end
                    end else if (r_used < FULL_COUNT) begin
                        // Free slot: the next one in fill order joins at the front.
                        data_we    = 1'b1;
                        data_waddr = r_used[IW-1:0];
                        n_v        = r_used[IW-1:0];
                        n_used     = r_used + CW'(1);
                        if (r_used == '0) begin
                            n_head = r_used[IW-1:0];
                            n_tail = r_used[IW-1:0];
                        end else begin
                            n_state = kedl_pkg::ST_LINK;
                        end
                    end else if (!in_window) begin
                        // Full table: the oldest entry gives its slot to the new key.
                        data_we    = 1'b1;
                        data_waddr = r_tail;
                        n_v        = r_tail;
                        n_vp       = r_tprev;
                        n_vtail    = 1'b1;
                        if (r_tail != r_head) begin
                            n_state = kedl_pkg::ST_UNLINK;
                        end
                    end
                end
            end

            kedl_pkg::ST_UNLINK: begin
                // Take the slot out of the list; the tail's forward link is never followed.
                if (r_vtail) begin
                    n_tail = r_vp;
                end else begin
                    link_we    = 1'b1;
                    next_waddr = r_vp;
                    next_wdata = r_vn;
                    prev_waddr = r_vn;
                    prev_wdata = r_vp;
                end
                n_state = kedl_pkg::ST_LINK;
            end

            kedl_pkg::ST_LINK: begin
                link_we    = 1'b1;
                next_waddr = r_v;
                next_wdata = r_head;
                prev_waddr = r_head;
                prev_wdata = r_v;
                n_head     = r_v;
                n_state    = kedl_pkg::ST_IDLE;
            end

            default: begin
                n_state = kedl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kedl_pkg::ST_IDLE;
            r_interval  <= '0;
            r_used      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_interval  <= n_interval;
            r_used      <= n_used;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_rvalid    <= n_rvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_now      <= n_now;
        r_cnt      <= n_cnt;
        r_ridx     <= n_ridx;
        r_hit      <= n_hit;
        r_htime    <= n_htime;
        r_ttime    <= n_ttime;
        r_tprev    <= n_tprev;
        r_v        <= n_v;
        r_vp       <= n_vp;
        r_vn       <= n_vn;
        r_vtail    <= n_vtail;
        r_dispatch <= n_dispatch;
    end

    kedl_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata ({r_now, r_key}),
        .i_re    (rd_en),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (data_rd)
    );

    kedl_ram #(
        .WIDTH (IW),
        .DEPTH (TABLE_DEPTH)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (rd_en),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (prev_rd)
    );

    kedl_ram #(
        .WIDTH (IW),
        .DEPTH (TABLE_DEPTH)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_re    (rd_en),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (next_rd)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == kedl_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(kedl_pkg::OUT_TDATA_W-1){1'b0}}, r_dispatch};

endmodule

FILE: sv/kedl_checker.sv
module kedl_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [kedl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // Requests accepted whose result has not been taken yet.
    logic [1:0] r_pend, n_pend;

    always_comb begin
        n_pend = r_pend;
        if ((s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)) begin
            n_pend = r_pend + 2'd1;
        end else if (!(s_axis_tvalid && s_axis_tready) && (m_axis_tvalid && m_axis_tready)) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Every result belongs to an accepted request.
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pend != 2'd0)
        else $error("result without a pending request");

    // At most one request in work and one result waiting.
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many requests in flight");

    // The padding above the dispatch bit stays zero.
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[kedl_pkg::OUT_TDATA_W-1:1] == '0)
        else $error("nonzero padding in result");

endmodule

bind keyed_event_debounce_lru_core kedl_checker u_kedl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
